FILE: hdl/u2l_pkg.sv
`timescale 1ns / 1ps
// u2l_pkg: types and constants of the UTF-8 to Latin-1 transcoder.
// No dependencies.
package u2l_pkg;

	localparam logic [7:0] LEAD2_LO  = 8'hC2;
	localparam logic [7:0] LEAD2_HI  = 8'hDF;
	localparam logic [7:0] LEAD3_LO  = 8'hE0;
	localparam logic [7:0] LEAD3_HI  = 8'hEF;
	localparam logic [7:0] LEAD4_LO  = 8'hF0;
	localparam logic [7:0] LEAD4_HI  = 8'hF4;
	localparam logic [7:0] SUBST     = 8'h3F;
	localparam logic [7:0] LATIN_MAX = 8'hFF;
	localparam int         MAX_RES   = 4;

	typedef struct packed {
		logic [7:0]  lead;
		logic [2:0]  exp_len;
		logic [1:0]  held_cnt;
		logic [20:0] acc;
	} u2l_state_t;

	typedef struct packed {
		logic [MAX_RES-1:0][7:0] bytes;
		logic [2:0]              cnt;
	} u2l_res_t;

endpackage

FILE: hdl/u2l_decode.sv
`timescale 1ns / 1ps
// u2l_decode: one-byte step of the UTF-8 decoder, combinational.
// Depends on u2l_pkg.
module u2l_decode import u2l_pkg::*; (
	input  logic            enable,
	input  logic [7:0]      in_byte,
	input  logic            last,
	input  u2l_state_t      cur,
	input  logic [1:0][7:0] held,
	output u2l_state_t      nxt,
	output logic [1:0][7:0] held_nxt,
	output u2l_res_t        res
);

	logic        open_seq;
	logic        is_cont;
	logic [2:0]  lead_len;
	logic [20:0] acc_new;
	logic [7:0]  cp_byte;
	logic        do_flush;
	logic [1:0]  fl_cnt;
	logic        tail_en;
	logic [7:0]  tail;
	logic [20:0] acc_init;

	assign open_seq = (cur.exp_len != 3'd0);
	assign is_cont  = (in_byte[7:6] == 2'b10);
	assign acc_new  = {cur.acc[14:0], in_byte[5:0]};
	assign cp_byte  = (acc_new <= {13'd0, LATIN_MAX}) ? acc_new[7:0] : SUBST;

	always_comb begin
		lead_len = 3'd1;
		acc_init = '0;
		if (in_byte >= LEAD2_LO && in_byte <= LEAD2_HI) begin
			lead_len = 3'd2;
			acc_init = {16'd0, in_byte[4:0]};
		end else if (in_byte >= LEAD3_LO && in_byte <= LEAD3_HI) begin
			lead_len = 3'd3;
			acc_init = {17'd0, in_byte[3:0]};
		end else if (in_byte >= LEAD4_LO && in_byte <= LEAD4_HI) begin
			lead_len = 3'd4;
			acc_init = {18'd0, in_byte[2:0]};
		end
	end

	always_comb begin
		nxt      = cur;
		held_nxt = held;
		do_flush = 1'b0;
		fl_cnt   = cur.held_cnt;
		tail_en  = 1'b0;
		tail     = in_byte;
		if (!enable) begin
			do_flush = open_seq;
			tail_en  = 1'b1;
			nxt      = '0;
		end else if (open_seq && is_cont) begin
			if (({1'b0, cur.held_cnt} + 3'd2) >= cur.exp_len) begin
				tail_en = 1'b1;
				tail    = cp_byte;
				nxt     = '0;
			end else begin
				held_nxt[cur.held_cnt[0]] = in_byte;
				nxt.held_cnt = cur.held_cnt + 2'd1;
				nxt.acc      = acc_new;
				if (last) begin
					do_flush = 1'b1;
					fl_cnt   = cur.held_cnt + 2'd1;
					nxt      = '0;
				end
			end
		end else begin
			do_flush = open_seq;
			nxt      = '0;
			if (lead_len == 3'd1 || last) begin
				tail_en = 1'b1;
			end else begin
				nxt.lead     = in_byte;
				nxt.exp_len  = lead_len;
				nxt.held_cnt = 2'd0;
				nxt.acc      = acc_init;
			end
		end
	end

	// raw flush first (lead, then held bytes), then the tail byte
	always_comb begin
		res = '0;
		if (do_flush) begin
			res.bytes[0] = cur.lead;
			res.cnt      = 3'd1;
			if (fl_cnt != 2'd0) begin
				res.bytes[1] = held_nxt[0];
				res.cnt      = 3'd2;
			end
			if (fl_cnt >= 2'd2) begin
				res.bytes[2] = held_nxt[1];
				res.cnt      = 3'd3;
			end
		end
		if (tail_en) begin
			res.bytes[res.cnt[1:0]] = tail;
			res.cnt = res.cnt + 3'd1;
		end
	end

endmodule

FILE: hdl/utf8_to_latin1_transcoder.sv
`timescale 1ns / 1ps
// utf8_to_latin1_transcoder: top level, UTF-8 byte stream to Latin-1 bytes.
// Depends on u2l_pkg and u2l_decode.
//
// Input channel (in_valid/in_ready) takes one UTF-8 byte per transaction,
// with end_of_text on the last byte. Output channel (out_valid/out_ready)
// gives zero to four Latin-1 bytes per input byte; run_last marks the last
// byte caused by one input, text_last the final byte of the text.
// cfg_wr_en/cfg_wr_data write transcode_enable (1 after reset); write it
// only while the block is idle.
// Data path: an accepted byte is held in the input register, is decoded
// into the result buffer once that buffer is free (a byte that yields no
// result only updates the decoder state), and its first result is driven
// from the result buffer register.
// Throughput: one byte per cycle while each byte yields at most one result
// and out_ready is high; a byte with several results holds the input while
// the single-entry result buffer drains one byte per cycle as out_ready allows.
// Reset clears the input register, result buffer and any open sequence.
// When out_ready is low the result buffer holds; the input register still
// accepts a byte if empty, and in_ready drops once it holds a byte with results.
module utf8_to_latin1_transcoder import u2l_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       text_last,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data
);

	logic            enable_q;
	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            last_s1;
	u2l_state_t      state_q;
	u2l_state_t      state_nxt;
	logic [1:0][7:0] held_q;
	logic [1:0][7:0] held_nxt;
	u2l_res_t        res;
	logic [MAX_RES-1:0][7:0] obuf_q;
	logic [2:0]      ocnt_q;
	logic [1:0]      oidx_q;
	logic            otext_q;
	logic            out_fire;
	logic            buf_free;
	logic            proc;
	logic            load;

	u2l_decode u_decode (
		.enable   (enable_q),
		.in_byte  (byte_s1),
		.last     (last_s1),
		.cur      (state_q),
		.held     (held_q),
		.nxt      (state_nxt),
		.held_nxt (held_nxt),
		.res      (res)
	);

	assign out_valid = (ocnt_q != 3'd0);
	assign out_byte  = obuf_q[oidx_q];
	assign run_last  = ({1'b0, oidx_q} == (ocnt_q - 3'd1));
	assign text_last = run_last && otext_q;
	assign out_fire  = out_valid && out_ready;
	assign buf_free  = !out_valid || (out_ready && run_last);
	assign proc      = valid_s1 && ((res.cnt == 3'd0) || buf_free);
	assign load      = proc && (res.cnt != 3'd0);
	assign in_ready  = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
		end else if (cfg_wr_en) begin
			enable_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (proc) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			held_q <= held_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ocnt_q  <= 3'd0;
			oidx_q  <= 2'd0;
			otext_q <= 1'b0;
		end else if (load) begin
			ocnt_q  <= res.cnt;
			oidx_q  <= 2'd0;
			otext_q <= last_s1;
		end else if (out_fire) begin
			if (run_last) begin
				ocnt_q <= 3'd0;
				oidx_q <= 2'd0;
			end else begin
				oidx_q <= oidx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			obuf_q <= res.bytes;
		end
	end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for utf8_to_latin1_transcoder. It streams bytes into the
// block and compares every output byte against a built-in Latin-1 transcoding predictor.
// Depends on u2l_pkg and the transcoder RTL.
module tb_top import u2l_pkg::*; ();

	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct packed {
		logic [7:0] b;
		logic       last;
	} text_item_t;

	typedef struct packed {
		logic [7:0] b;
		logic       run_last;
		logic       text_last;
	} latin_res_t;

	// bit 8 = end_of_text, bits 7:0 = byte
	localparam logic [8:0] DIRECTED [26] = '{
		9'h000, 9'h07F, 9'h080, 9'h0FF,
		9'h0C3, 9'h0A9, 9'h0DF, 9'h0BF,
		9'h0E0, 9'h080, 9'h080,
		9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,
		9'h0F0, 9'h09F, 9'h098, 9'h041,
		9'h0E2, 9'h082, 9'h0C3, 9'h0A9,
		9'h0E2, 9'h182, 9'h1C2
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'h00;
	logic       end_of_text = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       run_last;
	logic       text_last;
	logic       cfg_wr_en = 1'b0;
	logic       cfg_wr_data = 1'b0;

	text_item_t text_q[$];
	latin_res_t latin_q[$];
	logic [7:0] burst[$];

	// predictor state
	logic        tc_en = 1'b1;
	logic [7:0]  seq_lead = 8'h00;
	logic [2:0]  seq_len = 3'd0;
	logic [1:0]  seq_held = 2'd0;
	logic [7:0]  seq_hold [2] = '{8'h00, 8'h00};
	logic [20:0] seq_cp = 21'd0;

	logic in_taken = 1'b0;
	logic calm;
	int   in_count = 0;
	int   res_count = 0;
	int   err_cnt = 0;
	int   idle_cycles = 0;
	int   cfg_writes = 0;

	assign calm = (in_count >= 100 && in_count < 150);

	utf8_to_latin1_transcoder u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.run_last    (run_last),
		.text_last   (text_last),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always #6 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		err_cnt++;
	endtask

	function automatic int lead_len(input logic [7:0] b);
		if (b >= LEAD2_LO && b <= LEAD2_HI) return 2;
		if (b >= LEAD3_LO && b <= LEAD3_HI) return 3;
		if (b >= LEAD4_LO && b <= LEAD4_HI) return 4;
		return 1;
	endfunction

	task automatic close_open();
		seq_len = 3'd0;
		seq_held = 2'd0;
		seq_lead = 8'h00;
		seq_cp = 21'd0;
	endtask

	task automatic flush_open();
		if (seq_len != 3'd0) begin
			burst.push_back(seq_lead);
			for (int k = 0; k < int'(seq_held) && k < 2; k++)
				burst.push_back(seq_hold[k]);
			close_open();
		end
	endtask

	task automatic open_or_pass(input logic [7:0] b, input logic last);
		int len;
		len = lead_len(b);
		if (len == 1 || last) begin
			burst.push_back(b);
		end else begin
			seq_lead = b;
			seq_len = 3'(len);
			seq_held = 2'd0;
			seq_cp = 21'(b & (8'h7F >> len));
		end
	endtask

	task automatic predict_latin(input logic [7:0] b, input logic last);
		logic [20:0] cp;
		latin_res_t  r;
		burst.delete();
		if (!tc_en) begin
			flush_open();
			burst.push_back(b);
		end else if (seq_len != 3'd0) begin
			if (b[7:6] == 2'b10) begin
				seq_cp = {seq_cp[14:0], b[5:0]};
				if (int'(seq_held) + 2 >= int'(seq_len)) begin
					cp = seq_cp;
					close_open();
					burst.push_back((cp <= 21'(LATIN_MAX)) ? cp[7:0] : SUBST);
				end else begin
					seq_hold[seq_held[0]] = b;
					seq_held = seq_held + 2'd1;
					if (last) flush_open();
				end
			end else begin
				flush_open();
				open_or_pass(b, last);
			end
		end else begin
			open_or_pass(b, last);
		end
		foreach (burst[i]) begin
			r.b = burst[i];
			r.run_last = (i == burst.size() - 1);
			r.text_last = (i == burst.size() - 1) && last;
			latin_q.push_back(r);
		end
	endtask

	// driver: inputs change on the falling edge
	always @(negedge clk) begin
		text_item_t cur;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (text_q.size() != 0 && (calm || $urandom_range(99) >= 11)) begin
				cur = text_q.pop_front();
				in_valid <= 1'b1;
				in_byte <= cur.b;
				end_of_text <= cur.last;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= calm || ($urandom_range(99) >= 11);
	end

	// monitor, predictor and watchdog: sampled on the rising edge
	always @(posedge clk) begin
		latin_res_t want;
		in_taken <= in_valid && in_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				res_count++;
				if (latin_q.size() == 0) begin
					report_mismatch($sformatf("unexpected output byte %h", out_byte));
				end else begin
					want = latin_q.pop_front();
					if (out_byte !== want.b)
						report_mismatch($sformatf("out_byte %h, expected %h",
							out_byte, want.b));
					if (run_last !== want.run_last)
						report_mismatch($sformatf("run_last %b, expected %b on byte %h",
							run_last, want.run_last, want.b));
					if (text_last !== want.text_last)
						report_mismatch($sformatf("text_last %b, expected %b on byte %h",
							text_last, want.text_last, want.b));
				end
			end
			if (in_valid && in_ready) begin
				predict_latin(in_byte, end_of_text);
				in_count++;
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
					$display("Regression FAIL");
					$finish;
				end
			end
		end
	end

	task automatic push_item(input logic [7:0] b, input logic last);
		text_item_t t;
		t.b = b;
		t.last = last;
		text_q.push_back(t);
	endtask

	function automatic logic [7:0] rand_lead(input int len);
		case (len)
			2: return ($urandom_range(1) == 0) ? 8'(8'hC2 + $urandom_range(1))
				: 8'($urandom_range(LEAD2_HI, LEAD2_LO));
			3: return 8'($urandom_range(LEAD3_HI, LEAD3_LO));
			default: return 8'($urandom_range(LEAD4_HI, LEAD4_LO));
		endcase
	endfunction

	function automatic logic [7:0] rand_cont();
		return 8'h80 | 8'($urandom_range(63));
	endfunction

	// mostly well-formed UTF-8 with random content, plus broken and stray bytes
	task automatic gen_text(input int n);
		logic [7:0] unit[$];
		logic [7:0] b;
		int r, len, stop_at, cnt;
		bit ends;
		cnt = 0;
		while (cnt < n) begin
			unit.delete();
			r = $urandom_range(99);
			if (r < 30) begin
				unit.push_back(8'($urandom_range(8'h7F)));
			end else if (r < 72) begin
				len = (r < 50) ? 2 : (r < 62) ? 3 : 4;
				unit.push_back(rand_lead(len));
				repeat (len - 1) unit.push_back(rand_cont());
			end else if (r < 80) begin
				len = $urandom_range(4, 2);
				unit.push_back(rand_lead(len));
				repeat ($urandom_range(len - 2, 0)) unit.push_back(rand_cont());
				b = 8'($urandom_range(255));
				if (b[7:6] == 2'b10) b = b ^ 8'h40;
				unit.push_back(b);
			end else if (r < 90) begin
				unit.push_back(8'($urandom_range(255)));
			end else begin
				case ($urandom_range(2))
					0: unit.push_back(8'hC0 | 8'($urandom_range(1)));
					1: unit.push_back(8'($urandom_range(8'hFF, 8'hF5)));
					default: unit.push_back(rand_cont());
				endcase
			end
			stop_at = unit.size() - 1;
			ends = 1'b0;
			r = $urandom_range(99);
			if (r < 4) begin
				stop_at = $urandom_range(unit.size() - 1, 0);
				ends = 1'b1;
			end else if (r < 10) begin
				ends = 1'b1;
			end
			for (int i = 0; i <= stop_at; i++)
				push_item(unit[i], ends && i == stop_at);
			cnt += stop_at + 1;
		end
	endtask

	task automatic cfg_write(input logic v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		tc_en = v;
		cfg_writes++;
	endtask

	// wait for all traffic to drain, then let any zero-result byte clear the pipe
	task automatic drain(input int extra);
		while (text_q.size() != 0 || in_valid || latin_q.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		cfg_write(1'b1);
		foreach (DIRECTED[i]) push_item(DIRECTED[i][7:0], DIRECTED[i][8]);
		gen_text(80);
		// leave a sequence open across the enable change
		push_item(8'hE2, 1'b0);
		push_item(8'h82, 1'b0);
		drain(6);
		cfg_write(1'b0);
		gen_text(25);
		drain(6);
		cfg_write(1'b1);
		gen_text(45);
		push_item(8'hF0, 1'b0);
		push_item(8'h9F, 1'b0);
		push_item(8'h98, 1'b0);
		drain(6);
		cfg_write(1'b0);
		gen_text(5);
		drain(6);
		cfg_write(1'b1);
		gen_text(8);
		drain(10);
		if (latin_q.size() != 0)
			report_mismatch($sformatf("%0d expected bytes never arrived", latin_q.size()));
		$display("Covered %0d input bytes and %0d output bytes over %0d enable writes,",
			in_count, res_count, cfg_writes);
		$display("directed UTF-8 edge cases plus random mixed streams; %0d mismatches.",
			err_cnt);
		if (err_cnt == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

FILE: files.f
hdl/u2l_pkg.sv
hdl/u2l_decode.sv
hdl/utf8_to_latin1_transcoder.sv
tb/sv/tb_top.sv
